FILE: rtl/core/lsdc_pkg.sv
// Shared constants, types and codes of the LED synchronous detector.
// Used by every module in rtl/core; no dependencies.
`timescale 1ns / 1ps

package lsdc_pkg;

  // Sample and field widths
  localparam int SW   = 22;                              // converter sample bits
  localparam int DW   = SW + 1;                          // signed difference bits
  localparam int KW   = 16;                              // gain width, Q8.8
  localparam int TW   = 8;                               // toggle interval width
  localparam int RW   = 16;                              // report interval width
  localparam int CIW  = 8;                               // config index width
  localparam int CDW  = (SW > KW) ? SW : KW;             // config data width

  // Datapath widths of the shared multiply / divide unit
  localparam int MW   = (SW + 2 > KW + 1) ? SW + 2 : KW + 1; // multiplier operand
  localparam int PW   = 2 * MW;                          // product
  localparam int DENW = MW + KW + 2;                     // signed denominator
  localparam int DVW  = DENW - 1;                        // positive divisor
  localparam int QW   = PW + 8;                          // dividend / quotient
  localparam int QCW  = $clog2(QW);                      // divider step counter

  // Fixed values
  localparam int LED_VOLT_OFFSET = 1092267;
  localparam int NOM_RESET       = 2970000;
  localparam int GAIN_RESET      = 1587;
  localparam int TOGGLE_RESET    = 20;
  localparam int REPORT_RESET    = 100;

  // Configuration register indexes
  typedef enum logic [CIW-1:0] {
    REG_NOMINAL_LED_VOLT = 8'd0,
    REG_CORRECTION_GAIN  = 8'd1,
    REG_TOGGLE_INTERVAL  = 8'd2,
    REG_REPORT_INTERVAL  = 8'd3
  } cfg_idx_e;

  // Detector phases
  typedef enum logic [1:0] {
    PH_LED_ON       = 2'd0,
    PH_COLLECT_LIT  = 2'd1,
    PH_LED_OFF      = 2'd2,
    PH_COLLECT_DARK = 2'd3
  } phase_e;

  // Correction unit sequencer
  typedef enum logic [2:0] {
    CS_IDLE    = 3'd0,
    CS_MUL_DEN = 3'd1,
    CS_MUL_NUM = 3'd2,
    CS_SETUP   = 3'd3,
    CS_DIV     = 3'd4,
    CS_DONE    = 3'd5
  } calc_state_e;

  // Configuration register contents
  typedef struct packed {
    logic [SW-1:0] nom;
    logic [KW-1:0] gain;
    logic [TW-1:0] toggle;
    logic [RW-1:0] report;
  } cfg_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic report_fire;   // this transaction carries a report
    logic led_on_next;   // LED state after this transaction
    logic led_on;        // registered LED state
  } seq_stat_t;

  // Correction unit status
  typedef struct packed {
    logic busy;
    logic done;
  } calc_stat_t;

endpackage

FILE: rtl/core/lsdc_regs.sv
// Configuration register file of the LED synchronous detector.
// Depends on lsdc_pkg.
`timescale 1ns / 1ps

module lsdc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lsdc_pkg::CIW-1:0]    cfg_index_i,
  input  logic [lsdc_pkg::CDW-1:0]    cfg_data_i,
  output lsdc_pkg::cfg_t              cfg_o
);

  lsdc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lsdc_pkg::REG_NOMINAL_LED_VOLT: cfg_d.nom    = cfg_data_i[lsdc_pkg::SW-1:0];
        lsdc_pkg::REG_CORRECTION_GAIN:  cfg_d.gain   = cfg_data_i[lsdc_pkg::KW-1:0];
        lsdc_pkg::REG_TOGGLE_INTERVAL:  cfg_d.toggle = cfg_data_i[lsdc_pkg::TW-1:0];
        lsdc_pkg::REG_REPORT_INTERVAL:  cfg_d.report = cfg_data_i[lsdc_pkg::RW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nom    <= lsdc_pkg::SW'(lsdc_pkg::NOM_RESET);
      cfg_q.gain   <= lsdc_pkg::KW'(lsdc_pkg::GAIN_RESET);
      cfg_q.toggle <= lsdc_pkg::TW'(lsdc_pkg::TOGGLE_RESET);
      cfg_q.report <= lsdc_pkg::RW'(lsdc_pkg::REPORT_RESET);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/core/lsdc_seq.sv
// Tick sequencer: toggle and report counters, four-phase LED sequence and
// lit / dark sample latches. Depends on lsdc_pkg.
`timescale 1ns / 1ps

module lsdc_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tick_i,
  input  logic [lsdc_pkg::SW-1:0]   photo_i,
  input  logic [lsdc_pkg::SW-1:0]   led_volt_i,
  input  logic [lsdc_pkg::TW-1:0]   toggle_interval_i,
  input  logic [lsdc_pkg::RW-1:0]   report_interval_i,
  output lsdc_pkg::seq_stat_t       stat_o,
  output logic [lsdc_pkg::SW-1:0]   lit_photo_o,
  output logic [lsdc_pkg::SW-1:0]   dark_photo_o,
  output logic [lsdc_pkg::SW-1:0]   lit_volt_o,
  output logic [lsdc_pkg::SW-1:0]   dark_volt_o
);

  lsdc_pkg::phase_e              phase_q, phase_d;
  logic [lsdc_pkg::TW-1:0]       toggle_cnt_q, toggle_cnt_d;
  logic [lsdc_pkg::RW-1:0]       report_cnt_q, report_cnt_d;
  logic [lsdc_pkg::SW-1:0]       lit_photo_q, lit_photo_d, dark_photo_q, dark_photo_d;
  logic [lsdc_pkg::SW-1:0]       lit_volt_q, lit_volt_d, dark_volt_q, dark_volt_d;
  logic [lsdc_pkg::TW:0]         toggle_inc;
  logic [lsdc_pkg::RW:0]         report_inc;
  logic                          toggle_fire, report_fire;

  // Interval events; an interval of zero fires every tick as well
  assign toggle_inc  = {1'b0, toggle_cnt_q} + (lsdc_pkg::TW+1)'(1);
  assign report_inc  = {1'b0, report_cnt_q} + (lsdc_pkg::RW+1)'(1);
  assign toggle_fire = toggle_inc >= {1'b0, toggle_interval_i};
  assign report_fire = report_inc >= {1'b0, report_interval_i};

  // Next state on a tick
  always_comb begin
    phase_d      = phase_q;
    toggle_cnt_d = toggle_cnt_q;
    report_cnt_d = report_cnt_q;
    lit_photo_d  = lit_photo_q;
    dark_photo_d = dark_photo_q;
    lit_volt_d   = lit_volt_q;
    dark_volt_d  = dark_volt_q;
    if (tick_i) begin
      toggle_cnt_d = toggle_fire ? '0 : toggle_inc[lsdc_pkg::TW-1:0];
      report_cnt_d = report_fire ? '0 : report_inc[lsdc_pkg::RW-1:0];
      if (toggle_fire) begin
        unique case (phase_q)
          lsdc_pkg::PH_LED_ON: begin
            phase_d = lsdc_pkg::PH_COLLECT_LIT;
          end
          lsdc_pkg::PH_COLLECT_LIT: begin
            lit_photo_d = photo_i;
            lit_volt_d  = led_volt_i;
            phase_d     = lsdc_pkg::PH_LED_OFF;
          end
          lsdc_pkg::PH_LED_OFF: begin
            phase_d = lsdc_pkg::PH_COLLECT_DARK;
          end
          lsdc_pkg::PH_COLLECT_DARK: begin
            dark_photo_d = photo_i;
            dark_volt_d  = led_volt_i;
            phase_d      = lsdc_pkg::PH_LED_ON;
          end
          default: phase_d = lsdc_pkg::PH_LED_ON;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lsdc_pkg::PH_LED_ON;
      toggle_cnt_q <= '0;
      report_cnt_q <= '0;
      lit_photo_q  <= '0;
      dark_photo_q <= '0;
      lit_volt_q   <= '0;
      dark_volt_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      toggle_cnt_q <= toggle_cnt_d;
      report_cnt_q <= report_cnt_d;
      lit_photo_q  <= lit_photo_d;
      dark_photo_q <= dark_photo_d;
      lit_volt_q   <= lit_volt_d;
      dark_volt_q  <= dark_volt_d;
    end
  end

  // LED is lit in the first two phases
  assign stat_o.report_fire = report_fire;
  assign stat_o.led_on_next = (phase_d == lsdc_pkg::PH_LED_ON) ||
                              (phase_d == lsdc_pkg::PH_COLLECT_LIT);
  assign stat_o.led_on      = (phase_q == lsdc_pkg::PH_LED_ON) ||
                              (phase_q == lsdc_pkg::PH_COLLECT_LIT);

  assign lit_photo_o  = lit_photo_q;
  assign dark_photo_o = dark_photo_q;
  assign lit_volt_o   = lit_volt_q;
  assign dark_volt_o  = dark_volt_q;

endmodule

FILE: rtl/core/lsdc_calc.sv
// Drift correction unit: one shared signed multiplier and a restoring
// divider, one quotient bit per cycle, under a small sequencer.
// Depends on lsdc_pkg.
`timescale 1ns / 1ps

module lsdc_calc (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [lsdc_pkg::DW-1:0]   raw_i,
  input  logic signed [lsdc_pkg::DW-1:0]   vd_i,
  input  logic [lsdc_pkg::SW-1:0]          nom_i,
  input  logic [lsdc_pkg::KW-1:0]          gain_i,
  output lsdc_pkg::calc_stat_t             stat_o,
  output logic signed [lsdc_pkg::DW-1:0]   corr_o,
  output logic                             invalid_o
);

  lsdc_pkg::calc_state_e                   state_q, state_d;
  logic [lsdc_pkg::QCW-1:0]                cnt_q;
  logic signed [lsdc_pkg::PW-1:0]          prod_q;
  logic signed [lsdc_pkg::DENW-1:0]        den_q;
  logic [lsdc_pkg::DVW-1:0]                rem_q;
  logic [lsdc_pkg::QW-1:0]                 quo_q;
  logic                                    neg_q, inv_q;

  logic signed [lsdc_pkg::DW-1:0]          b_s;
  logic signed [lsdc_pkg::SW+1:0]          vn_s;
  logic signed [lsdc_pkg::MW-1:0]          mul_a, mul_b;
  logic signed [lsdc_pkg::PW-1:0]          mul_p;
  logic signed [lsdc_pkg::DENW-1:0]        den_sum;
  logic [lsdc_pkg::PW-1:0]                 prod_mag;
  logic [lsdc_pkg::DVW:0]                  shifted;
  logic [lsdc_pkg::DVW+1:0]                diff;
  logic                                    den_ok, last_step;
  logic [lsdc_pkg::QW-1:0]                 mag_lim;

  // b = nominal - offset, and (vd - nominal)
  assign b_s  = $signed({1'b0, nom_i}) - $signed(lsdc_pkg::DW'(lsdc_pkg::LED_VOLT_OFFSET));
  assign vn_s = (lsdc_pkg::SW+2)'(vd_i) - $signed({2'b00, nom_i});

  // Shared multiplier operand select
  always_comb begin
    unique case (state_q)
      lsdc_pkg::CS_MUL_DEN: begin
        mul_a = lsdc_pkg::MW'(vn_s);
        mul_b = lsdc_pkg::MW'($signed({1'b0, gain_i}));
      end
      default: begin
        mul_a = lsdc_pkg::MW'(raw_i);
        mul_b = lsdc_pkg::MW'(b_s);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Denominator: b * 256 + (vd - nominal) * gain
  assign den_sum = (lsdc_pkg::DENW'(b_s) <<< 8) + lsdc_pkg::DENW'(prod_q);
  assign den_ok  = den_q > lsdc_pkg::DENW'(0);

  // Numerator magnitude
  assign prod_mag = prod_q[lsdc_pkg::PW-1] ? lsdc_pkg::PW'(-prod_q) : lsdc_pkg::PW'(prod_q);

  // Restoring divider step
  assign shifted   = {rem_q, quo_q[lsdc_pkg::QW-1]};
  assign diff      = {1'b0, shifted} - {2'b00, den_q[lsdc_pkg::DVW-1:0]};
  assign last_step = cnt_q == lsdc_pkg::QCW'(lsdc_pkg::QW - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsdc_pkg::CS_IDLE:    if (start_i) state_d = lsdc_pkg::CS_MUL_DEN;
      lsdc_pkg::CS_MUL_DEN: state_d = lsdc_pkg::CS_MUL_NUM;
      lsdc_pkg::CS_MUL_NUM: state_d = lsdc_pkg::CS_SETUP;
      lsdc_pkg::CS_SETUP:   state_d = den_ok ? lsdc_pkg::CS_DIV : lsdc_pkg::CS_DONE;
      lsdc_pkg::CS_DIV:     if (last_step) state_d = lsdc_pkg::CS_DONE;
      lsdc_pkg::CS_DONE:    state_d = lsdc_pkg::CS_IDLE;
      default:              state_d = lsdc_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsdc_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lsdc_pkg::CS_MUL_DEN: begin
        prod_q <= mul_p;
      end
      lsdc_pkg::CS_MUL_NUM: begin
        den_q  <= den_sum;
        prod_q <= mul_p;
      end
      lsdc_pkg::CS_SETUP: begin
        inv_q <= !den_ok;
        neg_q <= prod_q[lsdc_pkg::PW-1];
        rem_q <= '0;
        quo_q <= {prod_mag, 8'h00};
        cnt_q <= '0;
      end
      lsdc_pkg::CS_DIV: begin
        cnt_q <= cnt_q + lsdc_pkg::QCW'(1);
        if (!diff[lsdc_pkg::DVW+1]) begin
          rem_q <= diff[lsdc_pkg::DVW-1:0];
          quo_q <= {quo_q[lsdc_pkg::QW-2:0], 1'b1};
        end else begin
          rem_q <= shifted[lsdc_pkg::DVW-1:0];
          quo_q <= {quo_q[lsdc_pkg::QW-2:0], 1'b0};
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  // Outputs: status and saturated, signed quotient
  always_comb begin
    stat_o.busy = state_q != lsdc_pkg::CS_IDLE;
    stat_o.done = state_q == lsdc_pkg::CS_DONE;
    invalid_o   = inv_q;
    mag_lim     = neg_q ? (lsdc_pkg::QW'(1) << lsdc_pkg::SW)
                        : ((lsdc_pkg::QW'(1) << lsdc_pkg::SW) - lsdc_pkg::QW'(1));
    if (inv_q) begin
      corr_o = '0;
    end else if (quo_q > mag_lim) begin
      corr_o = neg_q ? {1'b1, {(lsdc_pkg::DW-1){1'b0}}} : {1'b0, {(lsdc_pkg::DW-1){1'b1}}};
    end else begin
      corr_o = neg_q ? -$signed(quo_q[lsdc_pkg::DW-1:0]) : $signed(quo_q[lsdc_pkg::DW-1:0]);
    end
  end

endmodule

FILE: rtl/core/led_sync_detect_drift_correct_top.sv
// Top level of the LED synchronous detector with drift correction.
// Depends on lsdc_pkg, lsdc_regs, lsdc_seq and lsdc_calc.
`timescale 1ns / 1ps

// One input transaction is one millisecond tick. It steps the toggle and
// report counters and the four-phase LED sequence at once, and returns
// exactly one result transaction. A tick without a report is loaded straight
// into the output register, where its result sits the next cycle. A report
// tick runs the correction unit: two passes through the shared multiplier,
// a setup state, then a restoring divider that yields one quotient bit per
// cycle over 56 bits, and a done state to hand over the result, with
// in_stall_o high throughout; the next tick can be taken once the unit is
// idle again. A non-positive denominator skips the divider and goes from
// the setup state straight to the done state. A new tick is also held off
// while a finished result is stalled at the output. Configuration writes
// are taken at any time (cfg_ready_o stays high) but should only be issued
// while idle.
module led_sync_detect_drift_correct_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tick input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lsdc_pkg::SW-1:0]          photo_sample_i,
  input  logic [lsdc_pkg::SW-1:0]          led_volt_sample_i,
  input  logic [lsdc_pkg::SW-1:0]          thermistor_sample_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             led_on_o,
  output logic                             report_valid_o,
  output logic [lsdc_pkg::SW-1:0]          dark_value_o,
  output logic [lsdc_pkg::SW-1:0]          light_value_o,
  output logic signed [lsdc_pkg::DW-1:0]   raw_difference_o,
  output logic signed [lsdc_pkg::DW-1:0]   led_volt_difference_o,
  output logic signed [lsdc_pkg::DW-1:0]   corrected_value_o,
  output logic [lsdc_pkg::SW-1:0]          thermistor_value_o,
  output logic                             correction_invalid_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lsdc_pkg::CIW-1:0]         cfg_index_i,
  input  logic [lsdc_pkg::CDW-1:0]         cfg_data_i
);

  lsdc_pkg::cfg_t                   cfg;
  lsdc_pkg::seq_stat_t              seq_stat;
  lsdc_pkg::calc_stat_t             calc_stat;
  logic [lsdc_pkg::SW-1:0]          lit_photo, dark_photo, lit_volt, dark_volt;
  logic signed [lsdc_pkg::DW-1:0]   raw_diff, volt_diff, corr;
  logic                             corr_invalid;
  logic                             in_accept, load_plain, load_report, out_take;

  logic                             out_valid_q, out_valid_d;
  logic [lsdc_pkg::SW-1:0]          therm_q;
  logic                             led_on_q, report_q, invalid_q;
  logic [lsdc_pkg::SW-1:0]          dark_q, light_q, therm_out_q;
  logic signed [lsdc_pkg::DW-1:0]   raw_q, vdiff_q, corr_q;

  lsdc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lsdc_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tick_i            (in_accept),
    .photo_i           (photo_sample_i),
    .led_volt_i        (led_volt_sample_i),
    .toggle_interval_i (cfg.toggle),
    .report_interval_i (cfg.report),
    .stat_o            (seq_stat),
    .lit_photo_o       (lit_photo),
    .dark_photo_o      (dark_photo),
    .lit_volt_o        (lit_volt),
    .dark_volt_o       (dark_volt)
  );

  // Lit minus dark differences from the latched samples
  assign raw_diff  = $signed({1'b0, lit_photo}) - $signed({1'b0, dark_photo});
  assign volt_diff = $signed({1'b0, lit_volt})  - $signed({1'b0, dark_volt});

  lsdc_calc u_calc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (load_report),
    .raw_i     (raw_diff),
    .vd_i      (volt_diff),
    .nom_i     (cfg.nom),
    .gain_i    (cfg.gain),
    .stat_o    (calc_stat),
    .corr_o    (corr),
    .invalid_o (corr_invalid)
  );

  // Handshakes
  assign in_stall_o  = calc_stat.busy || (out_valid_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign load_plain  = in_accept && !seq_stat.report_fire;
  assign load_report = in_accept && seq_stat.report_fire;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_plain || calc_stat.done) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Thermistor sample held for the report of this tick
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      therm_q <= thermistor_sample_i;
    end
  end

  // Output register: plain tick result or finished report
  always_ff @(posedge clk_i) begin
    if (load_plain) begin
      led_on_q    <= seq_stat.led_on_next;
      report_q    <= 1'b0;
      dark_q      <= '0;
      light_q     <= '0;
      raw_q       <= '0;
      vdiff_q     <= '0;
      corr_q      <= '0;
      therm_out_q <= '0;
      invalid_q   <= 1'b0;
    end else if (calc_stat.done) begin
      led_on_q    <= seq_stat.led_on;
      report_q    <= 1'b1;
      dark_q      <= dark_photo;
      light_q     <= lit_photo;
      raw_q       <= raw_diff;
      vdiff_q     <= volt_diff;
      corr_q      <= corr;
      therm_out_q <= therm_q;
      invalid_q   <= corr_invalid;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign led_on_o              = led_on_q;
  assign report_valid_o        = report_q;
  assign dark_value_o          = dark_q;
  assign light_value_o         = light_q;
  assign raw_difference_o      = raw_q;
  assign led_volt_difference_o = vdiff_q;
  assign corrected_value_o     = corr_q;
  assign thermistor_value_o    = therm_out_q;
  assign correction_invalid_o  = invalid_q;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the LED synchronous detector with drift correction.
// Depends on lsdc_pkg and led_sync_detect_drift_correct_top with its submodules.
`timescale 1ns / 1ps

module testbench;
  import lsdc_pkg::*;

  localparam int MAXS = (1 << SW) - 1;
  localparam logic [CIW-1:0] REG_NONE = 8'hFF;   // no register behind this index

  // Expected contents of one result transaction
  typedef struct packed {
    logic          led_on;
    logic          report;
    logic [SW-1:0] dark;
    logic [SW-1:0] light;
    logic [DW-1:0] raw;
    logic [DW-1:0] vdiff;
    logic [DW-1:0] corr;
    logic [SW-1:0] therm;
    logic          invalid;
  } tick_result_t;

  typedef enum logic { ROW_TICK, ROW_CFG } row_kind_e;
  typedef enum logic [1:0] { CHK_MODEL, CHK_QUIET, CHK_INVALID } row_check_e;
  typedef enum logic [1:0] { STALL_NONE, STALL_RANDOM, STALL_PATTERN } stall_mode_e;

  typedef struct packed {
    row_kind_e      kind;
    logic [CIW-1:0] idx;
    logic [CDW-1:0] value;
    logic [SW-1:0]  photo;
    logic [SW-1:0]  ledv;
    logic [SW-1:0]  therm;
    row_check_e     chk;
    logic           led;
  } stim_row_t;

  // Directed table: config writes and ticks; typed expectations only where obvious
  stim_row_t plan [33] = '{
    '{ROW_TICK, REG_NONE, 0, 0, 0, 0, CHK_QUIET, 1'b1},
    '{ROW_TICK, REG_NONE, 0, MAXS, MAXS, MAXS, CHK_QUIET, 1'b1},
    '{ROW_CFG, REG_TOGGLE_INTERVAL, 1, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_CFG, REG_REPORT_INTERVAL, 1, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 5, 7, MAXS, CHK_INVALID, 1'b1},
    '{ROW_TICK, REG_NONE, 0, MAXS, 2900000, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 1, 1, 1, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 0, 0, 123, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 0, MAXS, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 0, 2900000, MAXS, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, MAXS, 0, MAXS, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, MAXS, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 777, MAXS, 777, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 1000, 1000, 1000, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, MAXS, MAXS, MAXS, CHK_MODEL, 1'b0},
    '{ROW_CFG, REG_CORRECTION_GAIN, 0, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_CFG, REG_NOMINAL_LED_VOLT, MAXS, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, MAXS, MAXS, 0, CHK_MODEL, 1'b0},
    '{ROW_CFG, REG_CORRECTION_GAIN, 16'hFFFF, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 0, 0, MAXS, CHK_MODEL, 1'b0},
    '{ROW_CFG, REG_NOMINAL_LED_VOLT, 0, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_CFG, REG_NOMINAL_LED_VOLT, LED_VOLT_OFFSET, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 3, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_CFG, REG_NONE, MAXS, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_CFG, REG_TOGGLE_INTERVAL, 0, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_CFG, REG_REPORT_INTERVAL, 0, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, MAXS, MAXS, MAXS, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, 0, 0, 0, CHK_MODEL, 1'b0},
    '{ROW_TICK, REG_NONE, 0, MAXS, 0, MAXS, CHK_MODEL, 1'b0}
  };

  // DUT ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [SW-1:0]        photo_sample_i = '0;
  logic [SW-1:0]        led_volt_sample_i = '0;
  logic [SW-1:0]        thermistor_sample_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 led_on_o;
  logic                 report_valid_o;
  logic [SW-1:0]        dark_value_o;
  logic [SW-1:0]        light_value_o;
  logic signed [DW-1:0] raw_difference_o;
  logic signed [DW-1:0] led_volt_difference_o;
  logic signed [DW-1:0] corrected_value_o;
  logic [SW-1:0]        thermistor_value_o;
  logic                 correction_invalid_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CIW-1:0]       cfg_index_i = '0;
  logic [CDW-1:0]       cfg_data_i = '0;

  // Detector state as the bench predicts it
  cfg_t          model_cfg;
  phase_e        det_phase;
  int unsigned   tog_cnt, rep_cnt;
  logic [SW-1:0] lit_pd, dark_pd, lit_lv, dark_lv;

  tick_result_t  results_due [$];
  bit            use_typed;
  tick_result_t  typed_result;
  int            ticks_taken = 0;
  int            err_count = 0;

  led_sync_detect_drift_correct_top DUT (.*);

  always #10 clk_i = ~clk_i;

  // Run limit
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic bit interval_elapsed(input int unsigned count, input int unsigned iv);
    return count + 1 >= ((iv == 0) ? 1 : iv);
  endfunction

  function automatic logic [SW-1:0] to_sample(input int v);
    if (v < 0) return '0;
    if (v > MAXS) return SW'(MAXS);
    return SW'(v);
  endfunction

  // One tick through the detector: phase step first, then the report
  task automatic sync_detect_tick(input logic [SW-1:0] photo, ledv, therm,
                                  output tick_result_t r);
    bit     hit;
    longint raw, vd, b, den, corr;
    r = '0;
    hit = interval_elapsed(tog_cnt, model_cfg.toggle);
    tog_cnt = hit ? 0 : tog_cnt + 1;
    if (hit) begin
      case (det_phase)
        PH_COLLECT_LIT: begin
          lit_pd = photo;
          lit_lv = ledv;
        end
        PH_COLLECT_DARK: begin
          dark_pd = photo;
          dark_lv = ledv;
        end
        default: ;
      endcase
      det_phase = phase_e'(det_phase + 2'd1);
    end
    r.led_on = (det_phase == PH_LED_ON) || (det_phase == PH_COLLECT_LIT);

    hit = interval_elapsed(rep_cnt, model_cfg.report);
    rep_cnt = hit ? 0 : rep_cnt + 1;
    if (hit) begin
      raw  = longint'(lit_pd) - longint'(dark_pd);
      vd   = longint'(lit_lv) - longint'(dark_lv);
      b    = longint'(model_cfg.nom) - longint'(LED_VOLT_OFFSET);
      den  = b * 256 + (vd - longint'(model_cfg.nom)) * longint'(model_cfg.gain);
      corr = 0;
      if (den <= 0) begin
        r.invalid = 1'b1;
      end else begin
        corr = (raw * b * 256) / den;   // truncates toward zero
        if (corr > MAXS) corr = MAXS;
        if (corr < -longint'(MAXS) - 1) corr = -longint'(MAXS) - 1;
      end
      r.report = 1'b1;
      r.dark   = dark_pd;
      r.light  = lit_pd;
      r.raw    = raw[DW-1:0];
      r.vdiff  = vd[DW-1:0];
      r.corr   = corr[DW-1:0];
      r.therm  = therm;
    end
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Called at a falling edge; returns at the edge that takes the transaction
  task automatic offer(input logic [SW-1:0] p, lv, th, input bit typed,
                       input tick_result_t want);
    use_typed = typed;
    typed_result = want;
    in_valid_i <= 1'b1;
    photo_sample_i <= p;
    led_volt_sample_i <= lv;
    thermistor_sample_i <= th;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop sending and wait until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Prediction on accepted ticks and config writes, checking of results
  always @(posedge clk_i) begin : scoreboard
    tick_result_t r, want;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_NOMINAL_LED_VOLT: model_cfg.nom = cfg_data_i[SW-1:0];
        REG_CORRECTION_GAIN:  model_cfg.gain = cfg_data_i[KW-1:0];
        REG_TOGGLE_INTERVAL:  model_cfg.toggle = cfg_data_i[TW-1:0];
        REG_REPORT_INTERVAL:  model_cfg.report = cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
    if (in_valid_i && !in_stall_o) begin
      sync_detect_tick(photo_sample_i, led_volt_sample_i, thermistor_sample_i, r);
      results_due.push_back(use_typed ? typed_result : r);
      ticks_taken++;
    end
    if (out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $error("result transaction with no tick outstanding");
        err_count++;
      end else begin
        want = results_due.pop_front();
        check_field("led_on", want.led_on, led_on_o);
        check_field("report_valid", want.report, report_valid_o);
        check_field("dark_value", want.dark, dark_value_o);
        check_field("light_value", want.light, light_value_o);
        check_field("raw_difference", $signed(want.raw), raw_difference_o);
        check_field("led_volt_difference", $signed(want.vdiff), led_volt_difference_o);
        check_field("corrected_value", $signed(want.corr), corrected_value_o);
        check_field("thermistor_value", want.therm, thermistor_value_o);
        check_field("correction_invalid", want.invalid, correction_invalid_o);
      end
    end
  end

  // Output side: stretches of no stall, random stall, a fixed pattern,
  // and two long hold-offs that back the block up into its input
  initial begin : receiver
    stall_mode_e mode;
    int span, beat, holds;
    beat = 0;
    holds = 0;
    forever begin
      if (holds < 2 && ticks_taken >= 200 + 600 * holds) begin
        holds++;
        repeat (400) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      mode = stall_mode_e'($urandom_range(0, 2));
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(negedge clk_i);
        beat++;
        case (mode)
          STALL_NONE:   out_stall_i <= 1'b0;
          STALL_RANDOM: out_stall_i <= ($urandom_range(0, 1) == 1);
          default:      out_stall_i <= ((beat % 5) < 3);
        endcase
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    tick_result_t   want;
    logic [SW-1:0]  p, lv, th;
    logic [CDW-1:0] rnd;
    logic [SW-1:0]  nom_v;
    logic [KW-1:0]  gain_v;
    logic [TW-1:0]  tog_v;
    logic [RW-1:0]  rep_v;
    int i, sent, phase_no, left, burst, gap;
    int pd_base, pd_signal, lv_base, lv_offset;
    bit lit;

    model_cfg.nom = SW'(NOM_RESET);
    model_cfg.gain = KW'(GAIN_RESET);
    model_cfg.toggle = TW'(TOGGLE_RESET);
    model_cfg.report = RW'(REPORT_RESET);
    det_phase = PH_LED_ON;
    tog_cnt = 0;
    rep_cnt = 0;
    lit_pd = '0;
    dark_pd = '0;
    lit_lv = '0;
    dark_lv = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (i = 0; i < $size(plan); i++) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        want = '0;
        want.led_on = plan[i].led;
        if (plan[i].chk == CHK_INVALID) begin
          want.report = 1'b1;
          want.therm = plan[i].therm;
          want.invalid = 1'b1;
        end
        @(negedge clk_i);
        offer(plan[i].photo, plan[i].ledv, plan[i].therm, plan[i].chk != CHK_MODEL, want);
      end
    end

    // Random phases, each under its own register setting
    sent = 0;
    phase_no = 0;
    while (sent < 1425) begin
      drain_results();
      case ($urandom_range(0, 4))
        0:       nom_v = SW'(NOM_RESET);
        1:       nom_v = '0;
        2:       nom_v = SW'(MAXS);
        3:       nom_v = SW'(LED_VOLT_OFFSET + $urandom_range(0, 2000));
        default: nom_v = SW'($urandom_range(1500000, 3500000));
      endcase
      case ($urandom_range(0, 3))
        0:       gain_v = '0;
        1:       gain_v = '1;
        2:       gain_v = KW'(GAIN_RESET);
        default: gain_v = KW'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       tog_v = '0;
        1:       tog_v = 8'd1;
        2:       tog_v = '1;
        3:       tog_v = TW'($urandom_range(1, 8));
        default: tog_v = TW'($urandom_range(1, 30));
      endcase
      case ($urandom_range(0, 3))
        0:       rep_v = '0;
        1:       rep_v = 16'd1;
        2:       rep_v = RW'($urandom_range(2, 10));
        default: rep_v = RW'($urandom_range(2, 60));
      endcase
      if (phase_no == 0) tog_v = '1;
      if (phase_no == 1) rep_v = '1;
      // narrow registers get random bits above their width
      write_reg(REG_NOMINAL_LED_VOLT, nom_v);
      rnd = CDW'($urandom);
      write_reg(REG_CORRECTION_GAIN, {rnd[CDW-1:KW], gain_v});
      rnd = CDW'($urandom);
      write_reg(REG_TOGGLE_INTERVAL, {rnd[CDW-1:TW], tog_v});
      rnd = CDW'($urandom);
      write_reg(REG_REPORT_INTERVAL, {rnd[CDW-1:RW], rep_v});
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, CDW'($urandom));

      // per-phase light and LED voltage levels
      pd_base   = $urandom_range(0, MAXS);
      pd_signal = int'($urandom_range(0, 2 * MAXS)) - MAXS;
      lv_base   = $urandom_range(0, 1000000);
      lv_offset = int'($urandom_range(0, 400000)) - 200000;

      left = (phase_no == 1) ? 40 : $urandom_range(60, 150);
      sent += left;
      while (left > 0) begin
        burst = $urandom_range(1, 40);
        if (burst > left) burst = left;
        left -= burst;
        repeat (burst) begin
          @(negedge clk_i);
          if ($urandom_range(0, 3) != 0) begin
            // follow the LED: lit samples while it is on, dark otherwise
            lit = (det_phase == PH_LED_ON) || (det_phase == PH_COLLECT_LIT);
            p  = to_sample(pd_base + (lit ? pd_signal : 0) +
                           int'($urandom_range(0, 2000)) - 1000);
            lv = to_sample(lv_base + (lit ? int'(model_cfg.nom) + lv_offset : 0) +
                           int'($urandom_range(0, 2000)) - 1000);
          end else begin
            p  = SW'($urandom);
            lv = SW'($urandom);
          end
          th = SW'($urandom);
          offer(p, lv, th, 1'b0, '0);
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
        end
      end
      phase_no++;
    end

    drain_results();
    repeat (70) @(posedge clk_i);
    if (err_count == 0 && results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
